@@ rtl/positional_list_engine_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Each macro checks a property on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
// check a property outside reset
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Word types and operation and status codes of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	// operation codes
	localparam logic [2:0] FN_INS_POS   = 3'd0;
	localparam logic [2:0] FN_INS_FRONT = 3'd1;
	localparam logic [2:0] FN_INS_BACK  = 3'd2;
	localparam logic [2:0] FN_DEL_POS   = 3'd3;
	localparam logic [2:0] FN_DEL_FRONT = 3'd4;
	localparam logic [2:0] FN_DEL_BACK  = 3'd5;
	localparam logic [2:0] FN_DUMP      = 3'd6;

	// result status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_BADPOS = 2'd1;
	localparam logic [1:0] STS_EMPTY  = 2'd2;
	localparam logic [1:0] STS_FULL   = 2'd3;

	// request word
	typedef struct packed {
		logic [2:0]   func;
		logic [4:0]   position;
		logic signed [31:0] value;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0]   status;
		logic signed [31:0] element;
		logic [4:0]   occupancy;
		logic         final_flag;
	} out_word_t;

	// result handed from the sequencer to the output buffer
	typedef struct packed {
		logic      load;
		out_word_t word;
	} res_push_t;

endpackage

`default_nettype wire

@@ rtl/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds when no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/ple_outbuf.sv @@
// ----------------------------------------------------------------------------
// ple_outbuf
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_outbuf
	import ple_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_push_t push,
	output logic           slot_free,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output out_word_t      rsp
);

	logic      valid_q;
	out_word_t word_q;

	// a new word may enter when the register is empty or drains this cycle
	assign slot_free = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = word_q;

	// track occupancy of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	// capture the word
	always_ff @(posedge clk) begin
		if (push.load) begin
			word_q <= push.word;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: decodes a request, shifts list entries through the RAM one
// entry per cycle and produces the result words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_engine_top_macros.svh"

module ple_ctrl
	import ple_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire in_word_t              req,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  slot_free,
	output res_push_t                  push,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [DATA_WIDTH-1:0]      wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  wire logic [DATA_WIDTH-1:0] rd_data
);

	localparam int CW = ((LW > 5) ? LW : 5) + 1;
	localparam int EW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_SH  = 3'd1;
	localparam logic [2:0] S_INS_PUT = 3'd2;
	localparam logic [2:0] S_DEL_GET = 3'd3;
	localparam logic [2:0] S_DEL_SH  = 3'd4;
	localparam logic [2:0] S_DUMP    = 3'd5;
	localparam logic [2:0] S_RESP    = 3'd6;

	logic [2:0]            state_q, state_d;
	logic [LW-1:0]         len_q, len_d;
	logic [AW-1:0]         ptr_q, ptr_d;
	logic [AW-1:0]         idx_q, idx_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic [1:0]            sts_q, sts_d;
	logic [31:0]           elem_q, elem_d;

	logic [CW-1:0]         pos_x, len_x;
	logic [AW-1:0]         pos_m1;
	logic [LW-1:0]         len_m1;
	logic                  at_tail;
	logic                  accept;
	logic                  ins_bad, is_full, del_bad, is_empty;
	logic [AW-1:0]         ins_idx;
	logic [31:0]           elem_rd;

	// request decode helpers
	assign accept   = req_valid && req_ready;
	assign pos_x    = CW'(req.position);
	assign len_x    = CW'(len_q);
	assign pos_m1   = AW'(pos_x - 1'b1);
	assign len_m1   = len_q - 1'b1;
	assign at_tail  = (LW'(ptr_q) == len_m1);
	assign is_empty = (len_q == '0);
	assign is_full  = (len_q == LW'(DEPTH));
	assign ins_bad  = (req.func == FN_INS_POS) &&
		((req.position == 5'd0) || (pos_x > len_x + 1'b1));
	assign del_bad  = (req.position == 5'd0) || (pos_x > len_x);
	assign elem_rd  = 32'(rd_data[EW-1:0]);
	assign req_ready = (state_q == S_IDLE);

	// pick the slot of a new element
	always_comb begin
		case (req.func)
			FN_INS_POS:   ins_idx = pos_m1;
			FN_INS_FRONT: ins_idx = '0;
			default:      ins_idx = AW'(len_q);
		endcase
	end

	// next state, RAM accesses and result words
	always_comb begin
		state_d = state_q;
		len_d   = len_q;
		ptr_d   = ptr_q;
		idx_d   = idx_q;
		val_d   = val_q;
		sts_d   = sts_q;
		elem_d  = elem_q;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_data;
		push    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					sts_d  = STS_OK;
					elem_d = '0;
					unique case (req.func) inside
						FN_INS_POS, FN_INS_FRONT, FN_INS_BACK: begin
							val_d = DATA_WIDTH'($unsigned(req.value));
							idx_d = ins_idx;
							if (ins_bad) begin
								sts_d   = STS_BADPOS;
								state_d = S_RESP;
							end else if (is_full) begin
								sts_d   = STS_FULL;
								state_d = S_RESP;
							end else if (LW'(ins_idx) == len_q) begin
								state_d = S_INS_PUT;
							end else begin
								// start the shift at the tail
								rd_en   = 1'b1;
								rd_addr = AW'(len_m1);
								ptr_d   = AW'(len_m1);
								state_d = S_INS_SH;
							end
						end
						FN_DEL_POS: begin
							if (del_bad) begin
								sts_d   = STS_BADPOS;
								state_d = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = pos_m1;
								ptr_d   = pos_m1;
								state_d = S_DEL_GET;
							end
						end
						FN_DEL_FRONT, FN_DEL_BACK: begin
							if (is_empty) begin
								sts_d   = STS_EMPTY;
								state_d = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = (req.func == FN_DEL_FRONT) ? '0 : AW'(len_m1);
								ptr_d   = (req.func == FN_DEL_FRONT) ? '0 : AW'(len_m1);
								state_d = S_DEL_GET;
							end
						end
						FN_DUMP: begin
							if (is_empty) begin
								sts_d   = STS_EMPTY;
								state_d = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								ptr_d   = '0;
								state_d = S_DUMP;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_INS_SH: begin
				// move the entry one slot up, walk toward the insert slot
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q + 1'b1);
				wr_data = rd_data;
				if (ptr_q == idx_q) begin
					state_d = S_INS_PUT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q - 1'b1);
					ptr_d   = AW'(ptr_q - 1'b1);
				end
			end
			S_INS_PUT: begin
				// drop the new element into its slot
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = val_q;
				len_d   = len_q + 1'b1;
				state_d = S_RESP;
			end
			S_DEL_GET: begin
				// hold the removed value, start closing the gap
				elem_d = elem_rd;
				if (at_tail) begin
					len_d   = len_m1;
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q + 1'b1);
					ptr_d   = AW'(ptr_q + 1'b1);
					state_d = S_DEL_SH;
				end
			end
			S_DEL_SH: begin
				// move the entry one slot down
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q - 1'b1);
				wr_data = rd_data;
				if (at_tail) begin
					len_d   = len_m1;
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q + 1'b1);
					ptr_d   = AW'(ptr_q + 1'b1);
				end
			end
			S_DUMP: begin
				// emit one element per free slot; read data holds while stalled
				if (slot_free) begin
					push.load            = 1'b1;
					push.word.status     = STS_OK;
					push.word.element    = elem_rd;
					push.word.occupancy  = 5'(len_q);
					push.word.final_flag = at_tail;
					if (at_tail) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(ptr_q + 1'b1);
						ptr_d   = AW'(ptr_q + 1'b1);
					end
				end
			end
			S_RESP: begin
				// hand over the single result word
				if (slot_free) begin
					push.load            = 1'b1;
					push.word.status     = sts_q;
					push.word.element    = elem_q;
					push.word.occupancy  = 5'(len_q);
					push.word.final_flag = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		idx_q  <= idx_d;
		val_q  <= val_d;
		sts_q  <= sts_d;
		elem_q <= elem_d;
	end

	`PLE_ASSERT(a_idle_no_write, (state_q == S_IDLE) |-> !wr_en, "write while idle")
	`PLE_ASSERT(a_no_rw_clash, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write collide")
	`PLE_ASSERT(a_len_step, !$stable(len_q) |-> ((len_q == $past(len_q) + 1'b1) || ($past(len_q) == len_q + 1'b1)), "length jumped")
	`PLE_ASSERT(a_push_room, push.load |-> slot_free, "result pushed into full buffer")
	`PLE_ASSERT(a_len_cap, len_q <= LW'(DEPTH), "length above capacity")

endmodule

`default_nettype wire

@@ rtl/positional_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to DEPTH values in a RAM with positional insert,
// delete and dump requests.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake            | Word
// --------+-----+----------------------+-----------------------------------
// req     | in  | req_valid/req_ready  | func, position, value
// rsp     | out | rsp_valid/rsp_ready  | status, element, occupancy, final
//
// A request is taken only while the sequencer is idle; it may be taken
// while the previous result still sits in the result register.
// Errors, unused codes and an empty dump go straight to the result. Insert
// shifts the entries at or above the insert slot up, delete the entries
// above the removed one down. Dump: one word per cycle while not stalled.
// The single RAM write port sets the one entry per cycle shift rate.
// A stalled result channel holds the sequencer at its next result word.
// Reset clears the length and the control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top
	import ple_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire in_word_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output out_word_t     rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;
	logic                  slot_free;
	res_push_t             push;

	// list storage
	ple_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// request sequencer
	ple_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.slot_free (slot_free),
		.push      (push),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// result register
	ple_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.slot_free (slot_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
